### rtl/lpb_pkg.sv
// Shared constants, reset values and controller/datapath interface types
// for the load-proportional LED blinker. No dependencies.
package lpb_pkg;

    // Fixed field widths.
    localparam int CNT_W  = 32;   // cumulative activity counters
    localparam int MAXP_W = 14;   // max_period register
    localparam int ITER_W = 30;   // iteration counter, holds ITER_LIMIT + 1

    // Default number of fraction bits of the fixed-point period.
    localparam int FRAC_BITS_DEF = 16;

    // Iteration count above which the counter and fire point restart.
    localparam logic [ITER_W-1:0] ITER_LIMIT = ITER_W'(1000000000);

    // Reset value of max_period.
    localparam logic [MAXP_W-1:0] MAX_PERIOD_RST = MAXP_W'(10000);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;      // take a tick request, flip phase, step iteration count
        logic sum;         // form the busy total
        logic delta;       // busy delta and grand total
        logic tdelta;      // grand total delta
        logic div_init;    // load the divider
        logic div_step;    // one restoring division step
        logic clamp;       // clamp the quotient into the period
        logic set_cap;     // period takes the cap directly
        logic fire;        // compare against the fire point
        logic finish;      // load the result register
    } lpb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic next_on;     // the tick being accepted is an on-phase tick
        logic busy_zero;   // busy delta is zero
        logic total_zero;  // grand total delta is zero
        logic div_last;    // divider is on its last step
        logic out_busy;    // result register still holds an untaken result
    } lpb_status_t;

endpackage

### rtl/lpb_ctrl.sv
// Controller state machine of the LED blinker: sequences one tick through
// the datapath. Depends on lpb_pkg for the command and status types.
module lpb_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lpb_pkg::lpb_status_t status,
    output lpb_pkg::lpb_cmd_t    cmd
);
    import lpb_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_DELTA,
        ST_TDELTA,
        ST_CLASSIFY,
        ST_DIV,
        ST_CLAMP,
        ST_FIRE,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   in_ready_next;

    assign in_ready = in_ready_reg;

    // Next state and command decode.
    always_comb
    begin
        state_next    = state_reg;
        in_ready_next = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready_next = 1'b1;
                if (in_valid && in_ready_reg)
                begin
                    cmd.accept    = 1'b1;
                    in_ready_next = 1'b0;
                    state_next    = status.next_on ? ST_SUM : ST_DONE;
                end
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_DELTA;
            end
            ST_DELTA:
            begin
                cmd.delta  = 1'b1;
                state_next = ST_TDELTA;
            end
            ST_TDELTA:
            begin
                cmd.tdelta = 1'b1;
                state_next = ST_CLASSIFY;
            end
            ST_CLASSIFY:
            begin
                // No activity at all: nothing fires.
                priority if (status.busy_zero && status.total_zero)
                begin
                    state_next = ST_DONE;
                end
                else if (status.busy_zero)
                begin
                    cmd.set_cap = 1'b1;
                    state_next  = ST_FIRE;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = ST_FIRE;
            end
            ST_FIRE:
            begin
                cmd.fire   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.finish    = 1'b1;
                    in_ready_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered ready.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_ready_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= in_ready_next;
        end
    end

endmodule

### rtl/lpb_dp.sv
// Datapath of the LED blinker: counter deltas, bit-serial restoring divider,
// period clamp, fire-point compare and result register. Depends on lpb_pkg.
module lpb_dp
#(
    parameter int FRAC_BITS = lpb_pkg::FRAC_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    input  logic [lpb_pkg::MAXP_W-1:0] cfg_data,
    input  logic [lpb_pkg::CNT_W-1:0]  user_ticks,
    input  logic [lpb_pkg::CNT_W-1:0]  system_ticks,
    input  logic [lpb_pkg::CNT_W-1:0]  nice_ticks,
    input  logic [lpb_pkg::CNT_W-1:0]  idle_ticks,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       led_on,
    output logic                       led_changed,
    input  lpb_pkg::lpb_cmd_t          cmd,
    output lpb_pkg::lpb_status_t       status
);
    import lpb_pkg::*;

    localparam int QW    = CNT_W + FRAC_BITS;   // quotient width
    localparam int PER_W = MAXP_W + FRAC_BITS;  // clamped period width
    localparam int NFP_W = ITER_W + FRAC_BITS;  // fire point width
    localparam int DC_W  = $clog2(QW + 1);      // divider step counter

    // Configuration and control state.
    logic [MAXP_W-1:0] max_period_reg;
    logic [CNT_W-1:0]  prev_busy_reg;
    logic [CNT_W-1:0]  prev_grand_reg;
    logic [ITER_W-1:0] iter_reg;
    logic [NFP_W-1:0]  nfp_reg;
    logic              off_phase_reg;
    logic              led_level_reg;
    logic              lit_reg;
    logic              out_valid_reg;
    logic [DC_W-1:0]   div_cnt_reg;

    // Payload registers.
    logic [CNT_W-1:0]  busy_part_reg;
    logic [CNT_W-1:0]  nice_reg;
    logic [CNT_W-1:0]  idle_reg;
    logic [CNT_W-1:0]  busy_reg;
    logic [CNT_W-1:0]  total_reg;
    logic [CNT_W-1:0]  busy_d_reg;
    logic [CNT_W-1:0]  total_d_reg;
    logic [QW-1:0]     quot_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [PER_W-1:0]  period_reg;
    logic              led_on_reg;
    logic              led_changed_reg;

    // Iteration count after the restart check.
    logic [ITER_W-1:0] iter_base;
    logic              iter_wrap;

    // Divider step.
    logic [CNT_W:0]    rem_sh;
    logic [CNT_W+1:0]  rem_diff;
    logic              q_bit;

    // Clamp and fire compare.
    logic [PER_W-1:0]  cap;
    logic [NFP_W:0]    fire_sum;
    logic [NFP_W-1:0]  now_fix;
    logic              fires;

    assign iter_wrap = (iter_reg > ITER_LIMIT);
    assign iter_base = iter_wrap ? '0 : iter_reg;

    assign rem_sh   = {rem_reg, quot_reg[QW-1]};
    assign rem_diff = {1'b0, rem_sh} - {2'b00, busy_d_reg};
    assign q_bit    = ~rem_diff[CNT_W+1];

    assign cap      = {max_period_reg, {FRAC_BITS{1'b0}}};
    assign now_fix  = {iter_reg, {FRAC_BITS{1'b0}}};
    assign fire_sum = {1'b0, nfp_reg} + (NFP_W + 1)'(period_reg);
    assign fires    = (fire_sum <= {1'b0, now_fix});

    // Status to the controller.
    always_comb
    begin
        status.next_on    = off_phase_reg;
        status.busy_zero  = (busy_d_reg == '0);
        status.total_zero = (total_d_reg == '0);
        status.div_last   = (div_cnt_reg == DC_W'(1));
        status.out_busy   = out_valid_reg && !out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign led_on      = led_on_reg;
    assign led_changed = led_changed_reg;

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_period_reg <= MAX_PERIOD_RST;
            prev_busy_reg  <= '0;
            prev_grand_reg <= '0;
            iter_reg       <= '0;
            nfp_reg        <= '0;
            off_phase_reg  <= 1'b0;
            led_level_reg  <= 1'b0;
            lit_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            div_cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                max_period_reg <= cfg_data;
            end

            // Tick request: restart check, phase flip, iteration step.
            if (cmd.accept)
            begin
                off_phase_reg <= ~off_phase_reg;
                lit_reg       <= 1'b0;
                if (off_phase_reg)
                begin
                    iter_reg <= iter_base + ITER_W'(1);
                end
                else
                begin
                    iter_reg <= iter_base;
                end
                if (iter_wrap)
                begin
                    nfp_reg <= '0;
                end
            end

            // Stored totals follow every on-phase tick.
            if (cmd.delta)
            begin
                prev_busy_reg <= busy_reg;
            end
            if (cmd.tdelta)
            begin
                prev_grand_reg <= total_reg;
            end

            // Divider step counter.
            if (cmd.div_init)
            begin
                div_cnt_reg <= DC_W'(QW);
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg - DC_W'(1);
            end

            // Fire when the period fits before the current iteration.
            if (cmd.fire && fires)
            begin
                lit_reg <= 1'b1;
                nfp_reg <= fire_sum[NFP_W-1:0];
            end

            // Result register handshake.
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                led_level_reg <= lit_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload pipeline and divider registers.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            busy_part_reg <= user_ticks + system_ticks;
            nice_reg      <= nice_ticks;
            idle_reg      <= idle_ticks;
        end
        if (cmd.sum)
        begin
            busy_reg <= busy_part_reg + nice_reg;
        end
        if (cmd.delta)
        begin
            busy_d_reg <= busy_reg - prev_busy_reg;
            total_reg  <= busy_reg + idle_reg;
        end
        if (cmd.tdelta)
        begin
            total_d_reg <= total_reg - prev_grand_reg;
        end

        // Restoring division, one quotient bit per cycle.
        if (cmd.div_init)
        begin
            quot_reg <= {total_d_reg, {FRAC_BITS{1'b0}}};
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            quot_reg <= {quot_reg[QW-2:0], q_bit};
            rem_reg  <= q_bit ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        end

        // Period: clamped quotient, or the cap when nothing was busy.
        if (cmd.set_cap)
        begin
            period_reg <= cap;
        end
        else if (cmd.clamp)
        begin
            period_reg <= (quot_reg > QW'(cap)) ? cap : quot_reg[PER_W-1:0];
        end

        if (cmd.finish)
        begin
            led_on_reg      <= lit_reg;
            led_changed_reg <= lit_reg ^ led_level_reg;
        end
    end

endmodule

### rtl/load_proportional_led_blinker.sv
// Load-proportional LED blinker, top level: controller and datapath.
// An off-phase tick request goes straight to the result register; an on-phase one first
// passes sum, delta, total delta and classify, then, as the deltas require, the bit-serial
// divider, clamp and fire. A new tick is taken only after the previous one is finished,
// also while the previous result still waits on the output.
// Reset (rst_n low, asynchronous) clears the control state, max_period to 10000.
module load_proportional_led_blinker
#(
    parameter int FRAC_BITS = lpb_pkg::FRAC_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [lpb_pkg::MAXP_W-1:0] cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [lpb_pkg::CNT_W-1:0]  user_ticks,
    input  logic [lpb_pkg::CNT_W-1:0]  system_ticks,
    input  logic [lpb_pkg::CNT_W-1:0]  nice_ticks,
    input  logic [lpb_pkg::CNT_W-1:0]  idle_ticks,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       led_on,
    output logic                       led_changed
);
    import lpb_pkg::*;

    lpb_cmd_t    cmd;
    lpb_status_t status;

    // The register write is always taken.
    assign cfg_ready = 1'b1;

    lpb_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lpb_dp
    #(
        .FRAC_BITS (FRAC_BITS)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .user_ticks   (user_ticks),
        .system_ticks (system_ticks),
        .nice_ticks   (nice_ticks),
        .idle_ticks   (idle_ticks),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .led_on       (led_on),
        .led_changed  (led_changed),
        .cmd          (cmd),
        .status       (status)
    );

endmodule
